// ----- src/cpba_pkg.sv -----
// Shared types and constants for the contiguous page bitmap allocator.
// Used by cpba_scan and the top level; no dependencies.
package cpba_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 11;
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNK_SHIFT = 3;
    localparam int RUN_W       = 12;

    localparam logic [ADDR_W-1:0] KERNEL_BASE_RST = 32'h0040_0000;
    localparam logic [ADDR_W-1:0] USER_BASE_RST   = 32'h0800_0000;

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // pool codes
    localparam logic POOL_KERNEL = 1'b0;
    localparam logic POOL_USER   = 1'b1;

    // register indexes
    localparam logic REG_KERNEL_BASE = 1'b0;
    localparam logic REG_USER_BASE   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC_BASE,
        ST_FREE_SETUP,
        ST_MK_RD,
        ST_MK_WR,
        ST_DONE
    } state_t;

    // result of scanning one bitmap chunk
    typedef struct packed {
        logic                   found;
        logic [CHUNK_SHIFT-1:0] pos;
        logic [RUN_W-1:0]       run;
    } scan_res_t;

endpackage

// ----- src/contiguous_page_bitmap_allocator.sv -----
// Contiguous page bitmap allocator: sequencer, config registers, result register.
// Depends on cpba_pkg, cpba_ram and cpba_scan.
//
// Usage: a request beat on s_* either allocates s_page_count pages from the
// pool s_pool (lowest free run first) or frees s_page_count pages starting at
// s_address (pool picked by comparing with user_base). One result beat on m_*
// per request: m_ok and m_start_address (0 on failure and on free).
// Both bitmaps sit in one RAM of 8-bit words; the scan reads one word per cycle.
// After reset a clearing pass writes every RAM word to free; no request is taken
// meanwhile, config writes are. Config writes go through cfg_we at any time and
// are expected only while idle.
// Flow: an allocate reads the words of its pool in order until the scan finds a
// run, then sets the run's pages by read-modify-write, and fails if none is found;
// a zero or oversize count fails without a scan. A free clears its pages likewise.
// One request at a time; s_ready is high only when idle. A finished result
// waits in the output register while the receiver stalls, and the next request
// is taken meanwhile; it only stalls when its own result is ready.
module contiguous_page_bitmap_allocator #(
    parameter int POOL_PAGES = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic                             s_pool,
    input  logic [cpba_pkg::ADDR_W-1:0]      s_address,
    input  logic [cpba_pkg::COUNT_W-1:0]     s_page_count,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_ok,
    output logic [cpba_pkg::ADDR_W-1:0]      m_start_address,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [cpba_pkg::ADDR_W-1:0]      cfg_wdata
);
    import cpba_pkg::*;

    localparam int IDX_W   = $clog2(POOL_PAGES) + 1;
    localparam int WORDS   = (POOL_PAGES + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int WA      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RA      = WA + 1;
    localparam int RDEPTH  = 2 ** RA;
    localparam int FIRST_W = ADDR_W - PAGE_SHIFT;
    localparam int CW      = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     kbase_reg, kbase_next;
    logic [ADDR_W-1:0]     ubase_reg, ubase_next;
    logic [RA-1:0]         clr_reg, clr_next;
    logic                  req_reg, req_next;
    logic                  pool_reg, pool_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [WA:0]           scan_word_reg, scan_word_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [WA-1:0]         rd_word_reg, rd_word_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic                  set_reg, set_next;
    logic                  res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_ok_reg, m_ok_next;
    logic [ADDR_W-1:0]     m_addr_reg, m_addr_next;

    logic                  ram_we;
    logic [RA-1:0]         ram_waddr;
    logic [CHUNK_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [RA-1:0]         ram_raddr;
    logic [CHUNK_BITS-1:0] ram_rdata;

    scan_res_t             scan;
    logic [IDX_W-1:0]      end_idx;
    logic [ADDR_W:0]       diff_u;
    logic [ADDR_W-1:0]     diff;
    logic [FIRST_W-1:0]    first;
    logic [CHUNK_SHIFT-1:0] lo;
    logic [CHUNK_SHIFT:0]  consumed;
    logic [CHUNK_BITS-1:0] mk_mask;

    cpba_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (RDEPTH)
    ) u_map (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    cpba_scan #(
        .POOL_PAGES (POOL_PAGES),
        .WA         (WA)
    ) u_scan (
        .bits   (ram_rdata),
        .word   (rd_word_reg),
        .run_in (run_reg),
        .count  (count_reg),
        .res    (scan)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_start_address = m_addr_reg;

    assign end_idx = IDX_W'({rd_word_reg, scan.pos});
    assign diff_u  = {1'b0, addr_reg} - {1'b0, ubase_reg};
    assign diff    = diff_u[ADDR_W] ? (addr_reg - kbase_reg) : diff_u[ADDR_W-1:0];
    assign first   = diff[ADDR_W-1:PAGE_SHIFT];
    assign lo      = cur_reg[CHUNK_SHIFT-1:0];
    assign consumed = (CHUNK_SHIFT+1)'(CHUNK_BITS) - {1'b0, lo};

    // bits of the current word that fall inside [cur, cur + rem) and the pool
    always_comb begin
        for (int k = 0; k < CHUNK_BITS; k++) begin
            mk_mask[k] = (CHUNK_SHIFT'(k) >= lo) &&
                (COUNT_W'(CHUNK_SHIFT'(k) - lo) < rem_reg) &&
                (32'({cur_reg[WA+CHUNK_SHIFT-1:CHUNK_SHIFT], CHUNK_SHIFT'(k)}) <
                 32'(POOL_PAGES));
        end
    end

    always_comb begin
        state_next     = state_reg;
        kbase_next     = kbase_reg;
        ubase_next     = ubase_reg;
        clr_next       = clr_reg;
        req_next       = req_reg;
        pool_next      = pool_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        scan_word_next = scan_word_reg;
        rd_vld_next    = 1'b0;
        rd_word_next   = rd_word_reg;
        run_next       = run_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        set_next       = set_reg;
        res_ok_next    = res_ok_reg;
        res_addr_next  = res_addr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_addr_next    = m_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = {pool_reg, cur_reg[WA+CHUNK_SHIFT-1:CHUNK_SHIFT]};
        ram_wdata      = set_reg ? (ram_rdata | mk_mask) : (ram_rdata & ~mk_mask);
        ram_re         = 1'b0;
        ram_raddr      = {pool_reg, cur_reg[WA+CHUNK_SHIFT-1:CHUNK_SHIFT]};

        if (cfg_we) begin
            case (cfg_index)
                REG_KERNEL_BASE: kbase_next = cfg_wdata;
                REG_USER_BASE:   ubase_next = cfg_wdata;
                default:         kbase_next = kbase_reg;
            endcase
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + RA'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    pool_next     = s_pool;
                    addr_next     = s_address;
                    count_next    = s_page_count;
                    scan_word_next = '0;
                    run_next      = '0;
                    if (s_req_type == REQ_FREE) begin
                        state_next = ST_FREE_SETUP;
                    end else if (s_page_count == '0 ||
                                 32'(s_page_count) > 32'(POOL_PAGES)) begin
                        res_ok_next   = 1'b0;
                        res_addr_next = '0;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read one word ahead; the registered RAM returns the data in the next cycle
                if (32'(scan_word_reg) < 32'(WORDS)) begin
                    ram_re         = 1'b1;
                    ram_raddr      = {pool_reg, scan_word_reg[WA-1:0]};
                    rd_vld_next    = 1'b1;
                    rd_word_next   = scan_word_reg[WA-1:0];
                    scan_word_next = scan_word_reg + (WA+1)'(1);
                end
                if (rd_vld_reg) begin
                    run_next = scan.run;
                    if (scan.found) begin
                        cur_next   = IDX_W'(CW'(end_idx) + CW'(1) - CW'(count_reg));
                        state_next = ST_ALLOC_BASE;
                    end else if (32'(rd_word_reg) == 32'(WORDS - 1)) begin
                        res_ok_next   = 1'b0;
                        res_addr_next = '0;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_ALLOC_BASE: begin
                res_ok_next   = 1'b1;
                res_addr_next = ((pool_reg == POOL_USER) ? ubase_reg : kbase_reg) +
                                (ADDR_W'(cur_reg) << PAGE_SHIFT);
                rem_next      = count_reg;
                set_next      = 1'b1;
                state_next    = ST_MK_RD;
            end
            ST_FREE_SETUP: begin
                pool_next     = diff_u[ADDR_W] ? POOL_KERNEL : POOL_USER;
                cur_next      = (32'(first) >= 32'(POOL_PAGES)) ?
                                IDX_W'(POOL_PAGES) : IDX_W'(first);
                rem_next      = count_reg;
                set_next      = 1'b0;
                res_ok_next   = 1'b1;
                res_addr_next = '0;
                state_next    = ST_MK_RD;
            end
            ST_MK_RD: begin
                if (rem_reg == '0 || 32'(cur_reg) >= 32'(POOL_PAGES)) begin
                    state_next = ST_DONE;
                end else begin
                    ram_re     = 1'b1;
                    state_next = ST_MK_WR;
                end
            end
            ST_MK_WR: begin
                ram_we   = 1'b1;
                rem_next = (COUNT_W'(consumed) >= rem_reg) ?
                           '0 : rem_reg - COUNT_W'(consumed);
                cur_next = (cur_reg & ~IDX_W'(CHUNK_BITS - 1)) + IDX_W'(CHUNK_BITS);
                state_next = ST_MK_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_addr_next  = res_addr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            kbase_reg   <= KERNEL_BASE_RST;
            ubase_reg   <= USER_BASE_RST;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            kbase_reg   <= kbase_next;
            ubase_reg   <= ubase_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        pool_reg      <= pool_next;
        addr_reg      <= addr_next;
        count_reg     <= count_next;
        scan_word_reg <= scan_word_next;
        rd_word_reg   <= rd_word_next;
        run_reg       <= run_next;
        cur_reg       <= cur_next;
        rem_reg       <= rem_next;
        set_reg       <= set_next;
        res_ok_reg    <= res_ok_next;
        res_addr_reg  <= res_addr_next;
        m_ok_reg      <= m_ok_next;
        m_addr_reg    <= m_addr_next;
    end

    // one request in flight: no second beat right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // only allocations scan the bitmap
    a_scan_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (req_reg == REQ_ALLOC))
        else $error("free request in scan");

    // read-modify-write never touches a page past the pool
    a_mk_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MK_WR) |-> (32'(cur_reg) < 32'(POOL_PAGES)))
        else $error("bitmap update past pool end");

    // a failed allocation reports a zero address
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_start_address == '0))
        else $error("failed allocation with nonzero address");

    // a fresh result beat only follows the done state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid)) |-> ($past(state_reg) == ST_DONE))
        else $error("result beat without completed request");

endmodule

// ----- src/cpba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/cpba_scan.sv -----
// Free-run scanner for one bitmap chunk: carries the running free count
// across chunks and reports the first position where the run reaches count.
// Depends on cpba_pkg.
module cpba_scan #(
    parameter int POOL_PAGES = 1024,
    parameter int WA         = 7
) (
    input  logic [cpba_pkg::CHUNK_BITS-1:0] bits,
    input  logic [WA-1:0]                   word,
    input  logic [cpba_pkg::RUN_W-1:0]      run_in,
    input  logic [cpba_pkg::COUNT_W-1:0]    count,
    output cpba_pkg::scan_res_t             res
);
    import cpba_pkg::*;

    logic [CHUNK_BITS-1:0] used;
    logic [CHUNK_BITS-1:0] hit;
    logic [RUN_W-1:0]      run_at [CHUNK_BITS];

    // pages past the end of the pool count as used
    always_comb begin
        for (int k = 0; k < CHUNK_BITS; k++) begin
            used[k] = bits[k] ||
                (32'({word, CHUNK_SHIFT'(k)}) >= 32'(POOL_PAGES));
        end
    end

    // run length ending at each position, all positions in parallel
    always_comb begin
        for (int j = 0; j < CHUNK_BITS; j++) begin
            logic                   seen;
            logic [CHUNK_SHIFT-1:0] span;
            seen = 1'b0;
            span = '0;
            for (int k = 0; k < CHUNK_BITS; k++) begin
                if (k <= j && used[k]) begin
                    seen = 1'b1;
                    span = CHUNK_SHIFT'(j - k);
                end
            end
            run_at[j] = seen ? RUN_W'(span) : run_in + RUN_W'(j + 1);
            hit[j]    = run_at[j] >= RUN_W'(count);
        end
    end

    always_comb begin
        res.found = |hit;
        res.pos   = '0;
        res.run   = run_at[CHUNK_BITS-1];
        for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                res.pos = CHUNK_SHIFT'(j);
            end
        end
    end

endmodule
